// ===== rtl/core/mosaic_block_average_macros.svh =====
// assertion macros for the mosaic block averager
`ifndef MOSAIC_BLOCK_AVERAGE_MACROS_SVH
`define MOSAIC_BLOCK_AVERAGE_MACROS_SVH

// same-cycle implication, checked out of reset
`define MBA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define MBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mba_pkg.sv =====
// shared types and constants of the mosaic block averager
`timescale 1ns / 1ps
package mba_pkg;
    localparam int DEF_MAX_REGION_WIDTH  = 4096;
    localparam int DEF_MAX_REGION_HEIGHT = 4096;
    localparam int DEF_MAX_BLOCK         = 255;

    localparam int PIX_W     = 8;
    localparam int SUM_W     = 24;
    localparam int CNT_W     = 16;
    localparam int IDX_W     = 12;
    localparam int DIM_W     = 13;
    localparam int BLK_W     = 8;
    localparam int DIV_STEPS = SUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [1:0] CFG_REGION_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_REGION_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_BLOCK_SIZE    = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_DIVIDE,
        ST_OUTPUT
    } t_state;

    typedef struct packed {
        logic clr_en;
        logic take;
        logic rd_en;
        logic upd;
        logic div_en;
        logic out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic clr_done;
        logic emit;
        logic div_done;
        logic out_busy;
    } t_ctrl_sts;
endpackage

// ===== rtl/core/mba_ctrl.sv =====
// controller state machine of the mosaic block averager
`timescale 1ns / 1ps
module mba_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  mba_pkg::t_ctrl_sts i_sts,
    output mba_pkg::t_ctrl_cmd o_cmd
);
    import mba_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_valid) n_state = ST_READ;
            end
            ST_READ: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                n_state = i_sts.emit ? ST_DIVIDE : ST_IDLE;
            end
            ST_DIVIDE: begin
                if (i_sts.div_done) n_state = ST_OUTPUT;
            end
            ST_OUTPUT: begin
                if (!i_sts.out_busy) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_en = 1'b1;
            end
            ST_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.take = i_valid;
            end
            ST_READ: begin
                o_cmd.rd_en = 1'b1;
            end
            ST_UPDATE: begin
                o_cmd.upd = 1'b1;
            end
            ST_DIVIDE: begin
                o_cmd.div_en = 1'b1;
            end
            ST_OUTPUT: begin
                o_cmd.out_load = !i_sts.out_busy;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end
endmodule

// ===== rtl/core/mba_dpath.sv =====
// datapath of the mosaic block averager: counters, column sums, divider, result register
`timescale 1ns / 1ps
module mba_dpath #(
    parameter int MAX_REGION_WIDTH  = mba_pkg::DEF_MAX_REGION_WIDTH,
    parameter int MAX_REGION_HEIGHT = mba_pkg::DEF_MAX_REGION_HEIGHT
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  mba_pkg::t_ctrl_cmd                       i_cmd,
    output mba_pkg::t_ctrl_sts                       o_sts,
    input  logic [mba_pkg::PIX_W-1:0]                i_pixel_blue,
    input  logic [mba_pkg::PIX_W-1:0]                i_pixel_green,
    input  logic [mba_pkg::PIX_W-1:0]                i_pixel_red,
    input  logic                                     i_region_start,
    input  logic [$clog2(MAX_REGION_WIDTH)-1:0]      i_w_m1,
    input  logic [$clog2(MAX_REGION_HEIGHT)-1:0]     i_h_m1,
    input  logic [mba_pkg::BLK_W-1:0]                i_b_m1,
    input  logic                                     i_stall,
    output logic                                     o_valid,
    output logic [mba_pkg::IDX_W-1:0]                o_block_column,
    output logic [mba_pkg::IDX_W-1:0]                o_block_row,
    output logic [mba_pkg::PIX_W-1:0]                o_average_blue,
    output logic [mba_pkg::PIX_W-1:0]                o_average_green,
    output logic [mba_pkg::PIX_W-1:0]                o_average_red,
    output logic [mba_pkg::CNT_W-1:0]                o_pixel_count
);
    import mba_pkg::*;

    localparam int XW = $clog2(MAX_REGION_WIDTH);
    localparam int YW = $clog2(MAX_REGION_HEIGHT);
    localparam int MW = 3 * SUM_W;

    logic [MW-1:0]    r_mem [MAX_REGION_WIDTH];
    logic [MW-1:0]    r_rd;
    logic [XW-1:0]    r_clr_addr;

    logic [XW-1:0]    r_px;
    logic [YW-1:0]    r_py;
    logic [BLK_W-1:0] r_obk;
    logic [BLK_W-1:0] r_obd;
    logic [XW-1:0]    r_bci;
    logic [YW-1:0]    r_band;
    logic [PIX_W-1:0] r_pix [3];

    logic [SUM_W-1:0] r_q   [3];
    logic [CNT_W-1:0] r_rem [3];
    logic [CNT_W-1:0] r_div;
    logic [STEP_W-1:0] r_step;
    logic [XW-1:0]    r_res_col;
    logic [YW-1:0]    r_res_row;

    logic [SUM_W-1:0] sum_new [3];
    logic             row_end, col_end, last_row, band_end;
    logic [BLK_W:0]   bw, bh;
    logic [2*BLK_W+1:0] area;

    // channel order in a memory word: blue low, red high
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_obd == '0) begin
                sum_new[k] = SUM_W'(r_pix[k]);
            end else begin
                sum_new[k] = r_rd[k*SUM_W +: SUM_W] + SUM_W'(r_pix[k]);
            end
        end
    end

    assign row_end  = r_px >= i_w_m1;
    assign col_end  = row_end || (r_obk >= i_b_m1);
    assign last_row = r_py >= i_h_m1;
    assign band_end = last_row || (r_obd >= i_b_m1);
    assign bw       = {1'b0, (r_obk < i_b_m1) ? r_obk : i_b_m1} + 1'b1;
    assign bh       = {1'b0, (r_obd < i_b_m1) ? r_obd : i_b_m1} + 1'b1;
    assign area     = bw * bh;

    assign o_sts.clr_done = r_clr_addr == XW'(MAX_REGION_WIDTH - 1);
    assign o_sts.emit     = col_end && band_end;
    assign o_sts.div_done = r_step == STEP_W'(DIV_STEPS - 1);
    assign o_sts.out_busy = o_valid && i_stall;

    // column sum memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_en) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_cmd.upd) begin
            r_mem[r_bci] <= {sum_new[2], sum_new[1], sum_new[0]};
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[r_bci];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px   <= '0;
            r_py   <= '0;
            r_obk  <= '0;
            r_obd  <= '0;
            r_bci  <= '0;
            r_band <= '0;
        end else if (i_cmd.take && i_region_start) begin
            r_px   <= '0;
            r_py   <= '0;
            r_obk  <= '0;
            r_obd  <= '0;
            r_bci  <= '0;
            r_band <= '0;
        end else if (i_cmd.upd) begin
            if (row_end) begin
                r_px  <= '0;
                r_obk <= '0;
                r_bci <= '0;
                if (last_row) begin
                    r_py   <= '0;
                    r_obd  <= '0;
                    r_band <= '0;
                end else begin
                    r_py <= r_py + 1'b1;
                    if (band_end) begin
                        r_obd  <= '0;
                        r_band <= r_band + 1'b1;
                    end else begin
                        r_obd <= r_obd + 1'b1;
                    end
                end
            end else begin
                r_px <= r_px + 1'b1;
                if (col_end) begin
                    r_obk <= '0;
                    r_bci <= r_bci + 1'b1;
                end else begin
                    r_obk <= r_obk + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_pix[0] <= i_pixel_blue;
            r_pix[1] <= i_pixel_green;
            r_pix[2] <= i_pixel_red;
        end
    end

    // restoring divider, one quotient bit per cycle, three lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_cmd.upd) begin
            r_step <= '0;
        end else if (i_cmd.div_en) begin
            r_step <= r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_div     <= area[CNT_W-1:0];
            r_res_col <= r_bci;
            r_res_row <= r_band;
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
        logic [CNT_W:0]   trial;
        logic             ge;
        assign trial = {r_rem[k], r_q[k][SUM_W-1]};
        assign ge    = trial >= {1'b0, r_div};
        always_ff @(posedge i_clk) begin
            if (i_cmd.upd) begin
                r_q[k]   <= sum_new[k];
                r_rem[k] <= '0;
            end else if (i_cmd.div_en) begin
                r_q[k]   <= {r_q[k][SUM_W-2:0], ge};
                r_rem[k] <= ge ? CNT_W'(trial - {1'b0, r_div}) : trial[CNT_W-1:0];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_valid <= 1'b1;
        end else if (o_valid && !i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_block_column  <= IDX_W'(r_res_col);
            o_block_row     <= IDX_W'(r_res_row);
            o_average_blue  <= r_q[0][PIX_W-1:0];
            o_average_green <= r_q[1][PIX_W-1:0];
            o_average_red   <= r_q[2][PIX_W-1:0];
            o_pixel_count   <= r_div;
        end
    end
endmodule

// ===== rtl/core/mosaic_block_average.sv =====
// top level of the mosaic block averager
`timescale 1ns / 1ps
// mosaic block averager: takes the pixels of a rectangle in raster order and,
// on the bottom-right pixel of each square block, returns the block's column
// and row index, its pixel count and the truncated blue, green and red
// averages. blocks on the right and bottom edges may be partial. a pixel
// passes three steps (accept, column-sum read, update); a pixel that finishes
// a block then runs through the bit-serial divider and a load of the result
// register, and waits there if the previous result is still stalled.
// after reset the column-sum memory is swept to zero, one column a cycle,
// over MAX_REGION_WIDTH columns, while input requests are stalled; register
// writes are taken throughout. registers may be written only between pixels.
module mosaic_block_average #(
    parameter int MAX_REGION_WIDTH  = mba_pkg::DEF_MAX_REGION_WIDTH,
    parameter int MAX_REGION_HEIGHT = mba_pkg::DEF_MAX_REGION_HEIGHT,
    parameter int MAX_BLOCK         = mba_pkg::DEF_MAX_BLOCK
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // register write port
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [1:0]                i_cfg_index,
    input  logic [mba_pkg::DIM_W-1:0] i_cfg_data,
    // pixel requests
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [mba_pkg::PIX_W-1:0] i_pixel_blue,
    input  logic [mba_pkg::PIX_W-1:0] i_pixel_green,
    input  logic [mba_pkg::PIX_W-1:0] i_pixel_red,
    input  logic                      i_region_start,
    // block results
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [mba_pkg::IDX_W-1:0] o_block_column,
    output logic [mba_pkg::IDX_W-1:0] o_block_row,
    output logic [mba_pkg::PIX_W-1:0] o_average_blue,
    output logic [mba_pkg::PIX_W-1:0] o_average_green,
    output logic [mba_pkg::PIX_W-1:0] o_average_red,
    output logic [mba_pkg::CNT_W-1:0] o_pixel_count
);
    import mba_pkg::*;
    `include "mosaic_block_average_macros.svh"

    localparam int XW = $clog2(MAX_REGION_WIDTH);
    localparam int YW = $clog2(MAX_REGION_HEIGHT);

    logic [DIM_W-1:0] r_region_width;
    logic [DIM_W-1:0] r_region_height;
    logic [BLK_W-1:0] r_block_size;

    logic [XW-1:0]    w_m1;
    logic [YW-1:0]    h_m1;
    logic [BLK_W-1:0] b_m1;

    t_ctrl_cmd cmd;
    t_ctrl_sts sts;

    // registers are always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_width  <= DIM_W'(1);
            r_region_height <= DIM_W'(1);
            r_block_size    <= BLK_W'(8);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_REGION_WIDTH:  r_region_width  <= i_cfg_data;
                CFG_REGION_HEIGHT: r_region_height <= i_cfg_data;
                CFG_BLOCK_SIZE:    r_block_size    <= i_cfg_data[BLK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // limits minus one: zero counts as one, oversize saturates at the maximum
    always_comb begin
        if (r_region_width == '0) begin
            w_m1 = '0;
        end else if ({1'b0, r_region_width} > (DIM_W + 1)'(MAX_REGION_WIDTH)) begin
            w_m1 = XW'(MAX_REGION_WIDTH - 1);
        end else begin
            w_m1 = XW'(r_region_width - 1'b1);
        end

        if (r_region_height == '0) begin
            h_m1 = '0;
        end else if ({1'b0, r_region_height} > (DIM_W + 1)'(MAX_REGION_HEIGHT)) begin
            h_m1 = YW'(MAX_REGION_HEIGHT - 1);
        end else begin
            h_m1 = YW'(r_region_height - 1'b1);
        end

        if (r_block_size == '0) begin
            b_m1 = '0;
        end else if (r_block_size > BLK_W'(MAX_BLOCK)) begin
            b_m1 = BLK_W'(MAX_BLOCK - 1);
        end else begin
            b_m1 = r_block_size - 1'b1;
        end
    end

    mba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    mba_dpath #(
        .MAX_REGION_WIDTH  (MAX_REGION_WIDTH),
        .MAX_REGION_HEIGHT (MAX_REGION_HEIGHT)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_pixel_blue    (i_pixel_blue),
        .i_pixel_green   (i_pixel_green),
        .i_pixel_red     (i_pixel_red),
        .i_region_start  (i_region_start),
        .i_w_m1          (w_m1),
        .i_h_m1          (h_m1),
        .i_b_m1          (b_m1),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_block_column  (o_block_column),
        .o_block_row     (o_block_row),
        .o_average_blue  (o_average_blue),
        .o_average_green (o_average_green),
        .o_average_red   (o_average_red),
        .o_pixel_count   (o_pixel_count)
    );

    // a waiting result is never overwritten
    `MBA_ASSERT_NOW(a_no_overwrite, cmd.out_load, !(o_valid && i_stall), "result overwritten")
    // an accepted pixel is followed by its column-sum read
    `MBA_ASSERT_NEXT(a_read_follows, cmd.take, cmd.rd_en, "missing column-sum read")
    // no new pixel while the divider is busy
    `MBA_ASSERT_NOW(a_div_excl, cmd.div_en, o_stall && !cmd.take, "pixel taken during divide")
endmodule
